>>> hdl/rpsm_pkg.sv
// ----------------------------------------------------------------------------
// rpsm_pkg
// Shared types and constants of the register pool spill manager.
// ----------------------------------------------------------------------------
package rpsm_pkg;

    localparam int NUM_SLOTS       = 32;
    localparam int POOL_FIRST      = 5;
    localparam int POOL_LAST       = 25;
    localparam int SNAPSHOT_LEVELS = 8;
    localparam int SLOT_W          = 5;
    localparam int SNAP_AW         = 8;

    typedef enum logic [1:0] {
        KIND_FREE = 2'd0,
        KIND_TEMP = 2'd1,
        KIND_VAR  = 2'd2,
        KIND_RSVD = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        REQ_ALLOC     = 4'd0,
        REQ_FREE_WB   = 4'd1,
        REQ_FREE_TEMP = 4'd2,
        REQ_FREE_NOWB = 4'd3,
        REQ_SAVE      = 4'd4,
        REQ_FREE_ALL  = 4'd5,
        REQ_DROP_ALL  = 4'd6,
        REQ_DIRTY     = 4'd7,
        REQ_UNBIND    = 4'd8,
        REQ_PUSH      = 4'd9,
        REQ_POP       = 4'd10,
        REQ_R11       = 4'd11,
        REQ_R12       = 4'd12,
        REQ_R13       = 4'd13,
        REQ_R14       = 4'd14,
        REQ_R15       = 4'd15
    } req_t;

    localparam logic [1:0] ACT_STORE = 2'd0;
    localparam logic [1:0] ACT_COPY  = 2'd1;
    localparam logic [1:0] ACT_LOAD  = 2'd2;
    localparam logic [1:0] ACT_DONE  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOSLOT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic [3:0]         req_type;
        logic [4:0]         reg_req;
        logic [15:0]        var_id;
        logic [4:0]         mem_base;
        logic signed [15:0] mem_offset;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [4:0]         dest_reg;
        logic [4:0]         src_reg;
        logic [4:0]         addr_base;
        logic signed [15:0] addr_offset;
        logic [1:0]         status;
        logic               last;
    } out_item_t;

    // One slot entry as held in the slot memory.
    typedef struct packed {
        kind_t       kind;
        logic        dirty;
        logic [15:0] var_id;
        logic [4:0]  base;
        logic [15:0] offset;
        logic [31:0] age;
    } slot_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_WAIT,
        S_DECIDE,
        S_SINGLE,
        S_SINGLE_WAIT,
        S_APPLY,
        S_SWEEP,
        S_SWEEP_WAIT,
        S_DONE
    } state_t;

endpackage

>>> hdl/rpsm_slot_ram.sv
// ----------------------------------------------------------------------------
// rpsm_slot_ram
// Slot memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rpsm_slot_ram
    import rpsm_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [SLOT_W-1:0] waddr,
    input  slot_t             wdata,
    input  logic [SLOT_W-1:0] raddr,
    output slot_t             rdata
);
    slot_t mem [NUM_SLOTS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> hdl/rpsm_snap_ram.sv
// ----------------------------------------------------------------------------
// rpsm_snap_ram
// Snapshot memory: one saved slot image per level and slot.
// ----------------------------------------------------------------------------
module rpsm_snap_ram
    import rpsm_pkg::*;
(
    input  logic               clk,
    input  logic               we,
    input  logic [SNAP_AW-1:0] waddr,
    input  slot_t              wdata,
    input  logic [SNAP_AW-1:0] raddr,
    output slot_t              rdata
);
    slot_t mem [256];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> hdl/register_pool_spill_manager_unit.sv
// ----------------------------------------------------------------------------
// register_pool_spill_manager_unit
// Register slot allocator with FIFO spill and a snapshot stack.
// ----------------------------------------------------------------------------
// Single-slot requests read, modify and write back one slot; pool requests (alloc
// temp, save) scan the 21 pool slots, reading each in turn; sweeps go over all 32
// slots (free all, drop all, push, pop). Every request can be held by output stalls.
// Requests are handled one at a time; the slot memory has a single read port.
// Reset (rst_n low, asynchronous) starts a clearing pass that writes every slot
// free; no item is accepted until it ends.
module register_pool_spill_manager_unit
    import rpsm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);
    typedef req_t req_type_t;

    // Clearing pass after reset.
    logic              clr_reg, clr_next;
    logic [SLOT_W-1:0] clr_idx_reg, clr_idx_next;

    state_t state_reg, state_next;
    in_item_t req_reg, req_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;

    // Pool scan results.
    logic              free_found_reg, free_found_next;
    logic [SLOT_W-1:0] free_idx_reg, free_idx_next;
    logic              vic_found_reg, vic_found_next;
    logic [SLOT_W-1:0] vic_idx_reg, vic_idx_next;
    logic [31:0]       vic_age_reg, vic_age_next;
    logic              hit_found_reg, hit_found_next;
    logic [SLOT_W-1:0] hit_idx_reg, hit_idx_next;

    // Decided target of a pool request and its pending actions.
    logic [SLOT_W-1:0] tgt_reg, tgt_next;
    logic              st_pend_reg, st_pend_next;
    logic              cp_pend_reg, cp_pend_next;
    logic [4:0]        st_base_reg, st_base_next;
    logic [15:0]       st_off_reg, st_off_next;
    logic              tgt_bind_reg, tgt_bind_next;

    logic [31:0]       age_reg, age_next;
    logic [3:0]        depth_reg, depth_next;
    logic [SLOT_W-1:0] granted_reg, granted_next;
    logic [1:0]        status_reg, status_next;

    out_item_t obuf_reg, obuf_next;
    logic      ovalid_reg, ovalid_next;

    logic              s_we;
    logic [SLOT_W-1:0] s_waddr, s_raddr;
    slot_t             s_wdata, s_rdata;
    logic              p_we;
    logic [SNAP_AW-1:0] p_waddr, p_raddr;
    slot_t             p_wdata, p_rdata;

    logic [SNAP_AW-1:0] push_base, pop_base;
    logic               in_take;
    logic               obuf_free;

    rpsm_slot_ram u_slot (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    rpsm_snap_ram u_snap (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    assign in_stall  = clr_reg || (state_reg != S_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_valid = ovalid_reg;
    assign out_data  = obuf_reg;
    assign obuf_free = !ovalid_reg || !out_stall;

    // Level = depth * 32 + slot, depth kept within the stack.
    assign push_base = {depth_reg[2:0], 5'd0};
    assign pop_base  = {3'(depth_reg - 4'd1), 5'd0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg     <= 1'b1;
            clr_idx_reg <= '0;
            state_reg   <= S_IDLE;
            age_reg     <= '0;
            depth_reg   <= '0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            clr_reg     <= clr_next;
            clr_idx_reg <= clr_idx_next;
            state_reg   <= state_next;
            age_reg     <= age_next;
            depth_reg   <= depth_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        idx_reg        <= idx_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        vic_found_reg  <= vic_found_next;
        vic_idx_reg    <= vic_idx_next;
        vic_age_reg    <= vic_age_next;
        hit_found_reg  <= hit_found_next;
        hit_idx_reg    <= hit_idx_next;
        tgt_reg        <= tgt_next;
        st_pend_reg    <= st_pend_next;
        cp_pend_reg    <= cp_pend_next;
        st_base_reg    <= st_base_next;
        st_off_reg     <= st_off_next;
        tgt_bind_reg   <= tgt_bind_next;
        granted_reg    <= granted_next;
        status_reg     <= status_next;
        obuf_reg       <= obuf_next;
    end

    always_comb
    begin
        slot_t cur;
        slot_t wr;
        clr_next        = clr_reg;
        clr_idx_next    = clr_idx_reg;
        state_next      = state_reg;
        req_next        = req_reg;
        idx_next        = idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        vic_found_next  = vic_found_reg;
        vic_idx_next    = vic_idx_reg;
        vic_age_next    = vic_age_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        tgt_next        = tgt_reg;
        st_pend_next    = st_pend_reg;
        cp_pend_next    = cp_pend_reg;
        st_base_next    = st_base_reg;
        st_off_next     = st_off_reg;
        tgt_bind_next   = tgt_bind_reg;
        age_next        = age_reg;
        depth_next      = depth_reg;
        granted_next    = granted_reg;
        status_next     = status_reg;
        obuf_next       = obuf_reg;
        ovalid_next     = ovalid_reg && out_stall;
        s_we    = 1'b0;
        s_waddr = idx_reg;
        s_wdata = s_rdata;
        s_raddr = idx_reg;
        p_we    = 1'b0;
        p_waddr = push_base | SNAP_AW'(idx_reg);
        p_wdata = s_rdata;
        p_raddr = pop_base | SNAP_AW'(idx_reg);
        cur     = s_rdata;
        wr      = s_rdata;

        if (clr_reg)
        begin
            s_we         = 1'b1;
            s_waddr      = clr_idx_reg;
            s_wdata      = '0;
            s_wdata.kind = KIND_FREE;
            clr_idx_next = clr_idx_reg + 1'b1;
            if (clr_idx_reg == SLOT_W'(NUM_SLOTS - 1))
            begin
                clr_next = 1'b0;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    req_next        = in_data;
                    granted_next    = '0;
                    status_next     = ST_OK;
                    free_found_next = 1'b0;
                    vic_found_next  = 1'b0;
                    hit_found_next  = 1'b0;
                    st_pend_next    = 1'b0;
                    cp_pend_next    = 1'b0;
                    tgt_bind_next   = 1'b0;
                    case (req_type_t'(in_data.req_type))
                        REQ_ALLOC, REQ_SAVE:
                        begin
                            idx_next   = SLOT_W'(POOL_FIRST);
                            state_next = S_SCAN;
                        end
                        REQ_FREE_WB, REQ_FREE_TEMP, REQ_FREE_NOWB, REQ_DIRTY,
                        REQ_UNBIND:
                        begin
                            idx_next   = in_data.reg_req;
                            state_next = S_SINGLE;
                        end
                        REQ_FREE_ALL, REQ_DROP_ALL:
                        begin
                            idx_next   = '0;
                            state_next = S_SWEEP;
                        end
                        REQ_PUSH:
                        begin
                            idx_next = '0;
                            if (depth_reg >= 4'(SNAPSHOT_LEVELS))
                            begin
                                status_next = ST_FULL;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SWEEP;
                            end
                        end
                        REQ_POP:
                        begin
                            idx_next = '0;
                            if (depth_reg == 4'd0)
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SWEEP;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                s_raddr    = idx_reg;
                state_next = S_SCAN_WAIT;
            end

            S_SCAN_WAIT:
            begin
                if (!free_found_reg && cur.kind == KIND_FREE)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = idx_reg;
                end
                if (!free_found_reg && cur.kind == KIND_VAR
                    && (!vic_found_reg || cur.age < vic_age_reg))
                begin
                    vic_found_next = 1'b1;
                    vic_idx_next   = idx_reg;
                    vic_age_next   = cur.age;
                end
                if (!hit_found_reg && cur.kind == KIND_VAR
                    && cur.var_id == req_reg.var_id)
                begin
                    hit_found_next = 1'b1;
                    hit_idx_next   = idx_reg;
                end
                if (idx_reg == SLOT_W'(POOL_LAST))
                begin
                    idx_next   = req_reg.reg_req;
                    s_raddr    = req_reg.reg_req;
                    state_next = S_DECIDE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SCAN;
                end
            end

            S_DECIDE:
            begin
                // s_rdata holds the slot named by reg_req; read the chosen target next.
                if (req_type_t'(req_reg.req_type) == REQ_SAVE && hit_found_reg)
                begin
                    tgt_next     = hit_idx_reg;
                    cp_pend_next = 1'b1;
                    granted_next = hit_idx_reg;
                    idx_next     = hit_idx_reg;
                    state_next   = S_SINGLE;
                end
                else if (req_type_t'(req_reg.req_type) == REQ_SAVE
                         && cur.kind == KIND_TEMP)
                begin
                    tgt_next      = req_reg.reg_req;
                    tgt_bind_next = 1'b1;
                    granted_next  = req_reg.reg_req;
                    idx_next      = req_reg.reg_req;
                    state_next    = S_SINGLE;
                end
                else if (free_found_reg || vic_found_reg)
                begin
                    tgt_next      = free_found_reg ? free_idx_reg : vic_idx_reg;
                    granted_next  = free_found_reg ? free_idx_reg : vic_idx_reg;
                    idx_next      = free_found_reg ? free_idx_reg : vic_idx_reg;
                    tgt_bind_next = (req_type_t'(req_reg.req_type) == REQ_SAVE);
                    cp_pend_next  = (req_type_t'(req_reg.req_type) == REQ_SAVE);
                    state_next    = S_SINGLE;
                end
                else
                begin
                    status_next = ST_NOSLOT;
                    state_next  = S_DONE;
                end
            end

            S_SINGLE:
            begin
                s_raddr    = idx_reg;
                state_next = S_SINGLE_WAIT;
            end

            S_SINGLE_WAIT:
            begin
                wr = cur;
                case (req_type_t'(req_reg.req_type))
                    REQ_ALLOC, REQ_SAVE:
                    begin
                        if (cp_pend_reg && !tgt_bind_reg)
                        begin
                            wr.dirty = 1'b1;
                        end
                        else
                        begin
                            if (cur.kind == KIND_VAR)
                            begin
                                // Evicted victim: store if dirty, restamp age.
                                st_pend_next = cur.dirty;
                                st_base_next = cur.base;
                                st_off_next  = cur.offset;
                                wr.age       = age_reg;
                                wr.dirty     = 1'b0;
                                age_next     = age_reg + 1'b1;
                            end
                            wr.kind = KIND_TEMP;
                            if (tgt_bind_reg)
                            begin
                                wr.kind   = KIND_VAR;
                                wr.var_id = req_reg.var_id;
                                wr.base   = req_reg.mem_base;
                                wr.offset = req_reg.mem_offset;
                                wr.dirty  = 1'b1;
                                wr.age    = (cur.kind == KIND_VAR) ? age_reg + 1'b1
                                                                   : age_reg;
                                age_next  = (cur.kind == KIND_VAR) ? age_reg + 32'd2
                                                                   : age_reg + 32'd1;
                            end
                        end
                    end
                    REQ_FREE_WB:
                    begin
                        st_pend_next = (cur.kind == KIND_VAR) && cur.dirty;
                        st_base_next = cur.base;
                        st_off_next  = cur.offset;
                        wr.kind  = KIND_FREE;
                        wr.dirty = 1'b0;
                    end
                    REQ_FREE_TEMP:
                    begin
                        if (cur.kind == KIND_TEMP)
                        begin
                            wr.kind  = KIND_FREE;
                            wr.dirty = 1'b0;
                        end
                    end
                    REQ_FREE_NOWB:
                    begin
                        wr.kind  = KIND_FREE;
                        wr.dirty = 1'b0;
                    end
                    REQ_DIRTY:  wr.dirty = 1'b1;
                    REQ_UNBIND: wr.kind  = KIND_TEMP;
                    default:    wr = cur;
                endcase
                s_we       = !clr_reg;
                s_waddr    = idx_reg;
                s_wdata    = wr;
                state_next = S_APPLY;
            end

            S_APPLY:
            begin
                // Emit a pending store (of a victim or a freed slot), then the copy of save.
                if (obuf_free)
                begin
                    if (st_pend_reg)
                    begin
                        obuf_next    = '0;
                        obuf_next.action      = ACT_STORE;
                        obuf_next.dest_reg    = idx_reg;
                        obuf_next.addr_base   = st_base_reg;
                        obuf_next.addr_offset = st_off_reg;
                        ovalid_next  = 1'b1;
                        st_pend_next = 1'b0;
                    end
                    else if (cp_pend_reg && req_type_t'(req_reg.req_type) == REQ_SAVE)
                    begin
                        obuf_next          = '0;
                        obuf_next.action   = ACT_COPY;
                        obuf_next.dest_reg = tgt_reg;
                        obuf_next.src_reg  = req_reg.reg_req;
                        ovalid_next  = 1'b1;
                        cp_pend_next = 1'b0;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_SWEEP:
            begin
                s_raddr    = idx_reg;
                p_raddr    = pop_base | SNAP_AW'(idx_reg);
                state_next = S_SWEEP_WAIT;
            end

            S_SWEEP_WAIT:
            begin
                if (obuf_free)
                begin
                    wr = cur;
                    case (req_type_t'(req_reg.req_type))
                        REQ_FREE_ALL, REQ_DROP_ALL:
                        begin
                            if (cur.kind == KIND_VAR)
                            begin
                                wr.kind  = KIND_FREE;
                                wr.dirty = 1'b0;
                                if (req_type_t'(req_reg.req_type) == REQ_FREE_ALL
                                    && cur.dirty)
                                begin
                                    obuf_next = '0;
                                    obuf_next.action      = ACT_STORE;
                                    obuf_next.dest_reg    = idx_reg;
                                    obuf_next.addr_base   = cur.base;
                                    obuf_next.addr_offset = cur.offset;
                                    ovalid_next = 1'b1;
                                end
                            end
                        end
                        REQ_PUSH:
                        begin
                            p_we    = 1'b1;
                            p_wdata = cur;
                            if (cur.kind != KIND_VAR)
                            begin
                                p_wdata      = '0;
                                p_wdata.kind = KIND_FREE;
                            end
                        end
                        REQ_POP:
                        begin
                            if (p_rdata.kind == KIND_VAR)
                            begin
                                wr = p_rdata;
                                obuf_next = '0;
                                obuf_next.action      = ACT_LOAD;
                                obuf_next.dest_reg    = idx_reg;
                                obuf_next.addr_base   = p_rdata.base;
                                obuf_next.addr_offset = p_rdata.offset;
                                ovalid_next = 1'b1;
                            end
                        end
                        default: wr = cur;
                    endcase
                    s_we    = !clr_reg;
                    s_waddr = idx_reg;
                    s_wdata = wr;
                    if (idx_reg == SLOT_W'(NUM_SLOTS - 1))
                    begin
                        if (req_type_t'(req_reg.req_type) == REQ_PUSH)
                        begin
                            depth_next = depth_reg + 4'd1;
                        end
                        if (req_type_t'(req_reg.req_type) == REQ_POP)
                        begin
                            depth_next = depth_reg - 4'd1;
                        end
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_SWEEP;
                    end
                end
            end

            S_DONE:
            begin
                if (obuf_free)
                begin
                    obuf_next          = '0;
                    obuf_next.action   = ACT_DONE;
                    obuf_next.dest_reg = granted_reg;
                    obuf_next.status   = status_reg;
                    obuf_next.last     = 1'b1;
                    ovalid_next        = 1'b1;
                    state_next         = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // No item is taken during the clearing pass after reset.
    a_no_take_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_reg |-> !in_take) else $error("item accepted during clear");
    // A held result keeps its value while stalled.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(out_data))
        else $error("stalled result changed");
    // The snapshot depth never passes the stack size.
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= 4'(SNAPSHOT_LEVELS)) else $error("snapshot depth overflow");
    // A taken request always moves the controller out of idle.
    a_idle_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> state_reg != S_IDLE) else $error("request lost");
`endif
endmodule
